>>> hw/rtl/dmc_pkg.sv
package dmc_pkg;

  // cache geometry
  localparam int unsigned LINES      = 4096;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTE_OFS_W = 2;
  localparam int unsigned IDX_W      = $clog2(LINES);
  localparam int unsigned TAG_W      = ADDR_W - BYTE_OFS_W - IDX_W;
  localparam int unsigned CNT_W      = 32;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // access kind and write policy codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam logic POLICY_WT  = 1'b0;
  localparam logic POLICY_WB  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] byte_address;
  } dmc_in_t;

  typedef struct packed {
    logic             hit;
    logic             mem_read;
    logic             mem_write;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
  } dmc_out_t;

  // classified access as it waits in the queue
  typedef struct packed {
    logic             is_write;
    logic             wb;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } dmc_item_t;

  // one row of the tag ram
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } dmc_row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } dmc_state_e;

endpackage

>>> hw/rtl/direct_mapped_cache_stats.sv
// path: an accepted item passes a queue slot, then cur_q with rd_q, then out_q
// back end: takes no new item until the tag ram read then write of the
//   current line is done, which waits until the previous result is popped
// reset: after rst_ni is released a clearing pass zeroes all 4096 tag ram
//   rows, one per cycle; full stays high throughout the pass
module direct_mapped_cache_stats import dmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  // write policy register
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  // access side
  input  logic     push,
  output logic     full,
  input  dmc_in_t  in_i,
  // result side
  output logic     empty,
  input  logic     pop,
  output dmc_out_t out_o
);

  // queue handoff from the classifying front to the tag ram back end
  logic      q_valid;
  logic      q_take;
  dmc_item_t q_item;
  logic      clearing;

  // front: policy register, address split, small queue
  dmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .in_i        (in_i),
    .hold_i      (clearing),
    .full_o      (full),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_take_i    (q_take)
  );

  // back: tag ram lookup and update, running counters, result register
  dmc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_take_o   (q_take),
    .clearing_o (clearing),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_o)
  );

endmodule

>>> hw/rtl/dmc_front.sv
module dmc_front import dmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      push_i,
  input  dmc_in_t   in_i,
  input  logic      hold_i,
  output logic      full_o,
  output logic      q_valid_o,
  output dmc_item_t q_item_o,
  input  logic      q_take_i
);

  logic              wb_q;
  dmc_item_t         slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  dmc_item_t         item_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= POLICY_WT;
    end else if (cfg_we_i) begin
      wb_q <= cfg_wdata_i;
    end
  end

  // split the byte address into line index and tag
  always_comb begin
    item_d.is_write = (in_i.func == FUNC_WRITE);
    item_d.wb       = wb_q;
    item_d.idx      = in_i.byte_address[BYTE_OFS_W +: IDX_W];
    item_d.tag      = in_i.byte_address[ADDR_W-1 -: TAG_W];
  end

  assign full_o    = (cnt_q == QCNT_W'(QDEPTH)) || hold_i;
  assign accept    = push_i && !full_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = accept   ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_take_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(accept) - QCNT_W'(q_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= item_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take_i |-> cnt_q != '0)
    else $error("take from empty queue");

  a_no_accept_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_i |=> cnt_q == $past(cnt_q) - QCNT_W'($past(q_take_i)))
    else $error("item entered queue during clearing");

endmodule

>>> hw/rtl/dmc_back.sv
module dmc_back import dmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  dmc_item_t q_item_i,
  output logic      q_take_o,
  output logic      clearing_o,
  input  logic      pop_i,
  output logic      empty_o,
  output dmc_out_t  out_o
);

  dmc_state_e       state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  dmc_item_t        cur_q;
  dmc_row_t         mem [LINES];
  dmc_row_t         rd_q;
  logic             rd_en;
  logic             we;
  logic [IDX_W-1:0] waddr;
  dmc_row_t         wdata;
  logic             out_free;
  logic             load;
  logic             out_valid_q;
  dmc_out_t         out_q;
  dmc_out_t         res;
  dmc_row_t         upd;
  logic [CNT_W-1:0] hits_q, misses_q, reads_q, writes_q;
  logic             hit, mem_write;

  assign out_free = !out_valid_q || pop_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IDX_W'(LINES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i) state_d = ST_LOOK;
      ST_LOOK:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // lookup and update of one line
  always_comb begin
    hit       = rd_q.valid && (rd_q.tag == cur_q.tag);
    mem_write = !hit && rd_q.valid && cur_q.wb && rd_q.dirty;
    upd.valid = 1'b1;
    upd.tag   = cur_q.tag;
    upd.dirty = (!hit && cur_q.wb) ? 1'b0 : rd_q.dirty;
    if (cur_q.is_write) begin
      if (cur_q.wb) begin
        upd.dirty = 1'b1;
      end else begin
        mem_write = 1'b1;
      end
    end
    res.hit         = hit;
    res.mem_read    = !hit;
    res.mem_write   = mem_write;
    res.hit_count   = hits_q + CNT_W'(hit);
    res.miss_count  = misses_q + CNT_W'(!hit);
    res.read_count  = reads_q + CNT_W'(!hit);
    res.write_count = writes_q + CNT_W'(mem_write);
  end

  // outputs
  always_comb begin
    q_take_o   = 1'b0;
    clearing_o = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    waddr      = cur_q.idx;
    wdata      = upd;
    load       = 1'b0;
    clr_d      = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        waddr      = clr_q;
        wdata      = '0;
        clr_d      = clr_q + 1'b1;
      end
      ST_IDLE: begin
        q_take_o = q_valid_i;
        rd_en    = q_valid_i;
      end
      ST_LOOK: begin
        we   = out_free;
        load = out_free;
      end
      default: begin
        clearing_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
        hits_q      <= res.hit_count;
        misses_q    <= res.miss_count;
        reads_q     <= res.read_count;
        writes_q    <= res.write_count;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      cur_q <= q_item_i;
    end
    if (load) begin
      out_q <= res;
    end
  end

  // tag ram, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[q_item_i.idx];
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || pop_i))
    else $error("result overwritten before pop");

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !q_take_o && !load)
    else $error("item handled during clearing pass");

  a_access_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> CNT_W'(out_q.hit_count + out_q.miss_count)
             == CNT_W'($past(hits_q) + $past(misses_q) + 1'b1))
    else $error("hit plus miss count did not advance by one");

  a_hit_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && res.hit && res.mem_write |-> cur_q.is_write && !cur_q.wb)
    else $error("memory write on hit outside write-through store");

endmodule
